FILE: src/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property on every rising edge of clk while rst_n is high.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checks that an expression never holds while out of reset.
`define ASSERT_NEVER(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`endif

FILE: src/rdc_pkg.sv
`timescale 1ns / 1ps

package rdc_pkg;

    localparam int VALUE_BITS  = 31;
    localparam int DIGIT_W     = 4;
    localparam int RADIX_W     = 4;
    localparam int STORE_DEPTH = VALUE_BITS + 1;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int COUNT_W     = $clog2(STORE_DEPTH + 1);
    localparam int SHIFT_W     = $clog2(VALUE_BITS + 1);

    localparam logic [RADIX_W-1:0] RADIX_RESET = RADIX_W'(10);
    localparam logic [RADIX_W-1:0] RADIX_MIN   = RADIX_W'(2);
    localparam logic [RADIX_W-1:0] RADIX_MAX   = RADIX_W'(10);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIVIDE,
        ST_RD_ADDR,
        ST_RD_DATA
    } state_t;

    // Status from the divider to the sequencer.
    typedef struct packed {
        logic done;
        logic nonzero;
    } div_status_t;

    function automatic logic [RADIX_W-1:0] eff_radix(input logic [RADIX_W-1:0] r);
        logic [RADIX_W-1:0] res;
        res = r;
        if (r < RADIX_MIN)
        begin
            res = RADIX_MIN;
        end
        else if (r > RADIX_MAX)
        begin
            res = RADIX_MAX;
        end
        return res;
    endfunction

endpackage

FILE: src/rdc_ram.sv
`timescale 1ns / 1ps

module rdc_ram #(
    parameter int WIDTH = 4,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: src/rdc_div.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

module rdc_div (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  logic [rdc_pkg::VALUE_BITS-1:0]    dividend,
    input  logic [rdc_pkg::RADIX_W-1:0]       radix,
    output logic [rdc_pkg::VALUE_BITS-1:0]    quotient,
    output logic [rdc_pkg::DIGIT_W-1:0]       remainder,
    output rdc_pkg::div_status_t              status
);

    // Long division, one dividend bit per cycle, most significant first.
    // The dividend shifts out of the top of quot_reg while quotient bits
    // shift in at the bottom.
    logic [rdc_pkg::VALUE_BITS-1:0] quot_reg, quot_next;
    logic [rdc_pkg::DIGIT_W-1:0]    rem_reg, rem_next;
    logic [rdc_pkg::SHIFT_W-1:0]    cnt_reg, cnt_next;
    logic                           done_reg, done_next;
    logic                           nz_reg, nz_next;
    logic [rdc_pkg::DIGIT_W:0]      trial;
    logic                           qbit;

    always_comb
    begin
        trial     = {rem_reg, quot_reg[rdc_pkg::VALUE_BITS-1]};
        qbit      = (trial >= {1'b0, radix});
        quot_next = quot_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        nz_next   = nz_reg;
        done_next = 1'b0;
        if (start)
        begin
            quot_next = dividend;
            rem_next  = '0;
            cnt_next  = rdc_pkg::SHIFT_W'(rdc_pkg::VALUE_BITS);
            nz_next   = 1'b0;
        end
        else if (cnt_reg != '0)
        begin
            quot_next = {quot_reg[rdc_pkg::VALUE_BITS-2:0], qbit};
            if (qbit)
            begin
                rem_next = rdc_pkg::DIGIT_W'(trial - {1'b0, radix});
            end
            else
            begin
                rem_next = trial[rdc_pkg::DIGIT_W-1:0];
            end
            nz_next   = nz_reg | qbit;
            cnt_next  = cnt_reg - rdc_pkg::SHIFT_W'(1);
            done_next = (cnt_reg == rdc_pkg::SHIFT_W'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
            nz_reg   <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
            nz_reg   <= nz_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quot_reg <= quot_next;
        rem_reg  <= rem_next;
    end

    assign quotient       = quot_reg;
    assign remainder      = rem_reg;
    assign status.done    = done_reg;
    assign status.nonzero = nz_reg;

    `ASSERT_CLK(a_rem_below_radix, done_reg |-> (rem_reg < radix), "remainder not below radix")
    `ASSERT_NEVER(a_start_while_busy, start && (cnt_reg != '0), "division restarted while busy")

endmodule

FILE: src/radix_digit_converter_top.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Converts each accepted value into its digits in the configured radix (2..10; lower
// register values act as 2, higher ones as 10) and sends them most significant first,
// with last set on the final digit; zero gives one digit 0. Digits are found by a
// bit-serial divider, least significant first into a small digit RAM, then read back
// in reverse, each digit through an address state and a data state. A new value is
// taken only when the previous run has been read out; the last digit may still sit
// in the output register. Write radix only while no request is in progress.
module radix_digit_converter_top (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [rdc_pkg::RADIX_W-1:0]       radix,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [rdc_pkg::VALUE_BITS-1:0]    value,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [rdc_pkg::DIGIT_W-1:0]       digit,
    output logic                              last
);

    rdc_pkg::state_t                state_reg, state_next;
    logic [rdc_pkg::RADIX_W-1:0]    radix_reg;
    logic [rdc_pkg::RADIX_W-1:0]    radix_eff;
    logic [rdc_pkg::COUNT_W-1:0]    n_reg, n_next;
    logic [rdc_pkg::ADDR_W-1:0]     rd_idx_reg, rd_idx_next;
    logic                           out_valid_reg;
    logic [rdc_pkg::DIGIT_W-1:0]    digit_reg;
    logic                           last_reg;

    logic                           div_start;
    logic [rdc_pkg::VALUE_BITS-1:0] div_dividend;
    logic [rdc_pkg::VALUE_BITS-1:0] div_quot;
    logic [rdc_pkg::DIGIT_W-1:0]    div_rem;
    rdc_pkg::div_status_t           div_status;

    logic                           ram_we;
    logic                           ram_re;
    logic [rdc_pkg::DIGIT_W-1:0]    ram_rd_data;
    logic                           out_load;

    assign cfg_ready = 1'b1;
    assign radix_eff = rdc_pkg::eff_radix(radix_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radix_reg <= rdc_pkg::RADIX_RESET;
        end
        else if (cfg_valid)
        begin
            radix_reg <= radix;
        end
    end

    // The first division starts from the input value, later ones from the quotient.
    assign div_dividend = (state_reg == rdc_pkg::ST_IDLE) ? value : div_quot;

    rdc_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (div_dividend),
        .radix     (radix_eff),
        .quotient  (div_quot),
        .remainder (div_rem),
        .status    (div_status)
    );

    rdc_ram #(
        .WIDTH (rdc_pkg::DIGIT_W),
        .DEPTH (rdc_pkg::STORE_DEPTH)
    ) u_store (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (n_reg[rdc_pkg::ADDR_W-1:0]),
        .wr_data (div_rem),
        .rd_en   (ram_re),
        .rd_addr (rd_idx_reg),
        .rd_data (ram_rd_data)
    );

    always_comb
    begin
        state_next  = state_reg;
        n_next      = n_reg;
        rd_idx_next = rd_idx_reg;
        in_ready    = 1'b0;
        div_start   = 1'b0;
        ram_we      = 1'b0;
        ram_re      = 1'b0;
        out_load    = 1'b0;
        case (state_reg)
            rdc_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    div_start  = 1'b1;
                    n_next     = '0;
                    state_next = rdc_pkg::ST_DIVIDE;
                end
            end
            rdc_pkg::ST_DIVIDE:
            begin
                if (div_status.done)
                begin
                    ram_we = 1'b1;
                    n_next = n_reg + rdc_pkg::COUNT_W'(1);
                    if (!div_status.nonzero ||
                        n_reg == rdc_pkg::COUNT_W'(rdc_pkg::STORE_DEPTH - 1))
                    begin
                        rd_idx_next = n_reg[rdc_pkg::ADDR_W-1:0];
                        state_next  = rdc_pkg::ST_RD_ADDR;
                    end
                    else
                    begin
                        div_start = 1'b1;
                    end
                end
            end
            rdc_pkg::ST_RD_ADDR:
            begin
                ram_re     = 1'b1;
                state_next = rdc_pkg::ST_RD_DATA;
            end
            rdc_pkg::ST_RD_DATA:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_load = 1'b1;
                    if (rd_idx_reg == '0)
                    begin
                        state_next = rdc_pkg::ST_IDLE;
                    end
                    else
                    begin
                        rd_idx_next = rd_idx_reg - rdc_pkg::ADDR_W'(1);
                        state_next  = rdc_pkg::ST_RD_ADDR;
                    end
                end
            end
            default:
            begin
                state_next = rdc_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= rdc_pkg::ST_IDLE;
            n_reg         <= '0;
            rd_idx_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            n_reg      <= n_next;
            rd_idx_reg <= rd_idx_next;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            digit_reg <= ram_rd_data;
            last_reg  <= (rd_idx_reg == '0);
        end
    end

    assign out_valid = out_valid_reg;
    assign digit     = digit_reg;
    assign last      = last_reg;

    `ASSERT_CLK(a_count_in_range, n_reg <= rdc_pkg::COUNT_W'(rdc_pkg::STORE_DEPTH), "digit count overflow")
    `ASSERT_CLK(a_last_to_idle, (out_load && rd_idx_reg == '0) |=> (state_reg == rdc_pkg::ST_IDLE), "run did not end after last digit")
    `ASSERT_CLK(a_digit_in_radix, out_valid_reg |-> (digit_reg < radix_eff), "digit not below radix")

endmodule
